// ----- src/mmtb_pkg.sv -----
// Shared types and constants for the transposed-B matrix multiply block.
// Holds the request/response payload structs, operation codes, CSR indexes
// and the control word that travels down the multiply-accumulate pipeline.
`default_nettype none

package mmtb_pkg;

   localparam int ELEM_FIELD_BITS = 16;
   localparam int RES_BITS        = 40;
   localparam int IDX_FIELD_BITS  = 6;
   localparam int CSR_IDX_BITS    = 2;
   localparam int CSR_DATA_BITS   = 7;
   localparam int BIAS_SHIFT      = 8;

   typedef enum logic [1:0] {
      OP_LOAD_A    = 2'd0,
      OP_LOAD_B    = 2'd1,
      OP_LOAD_BIAS = 2'd2,
      OP_COMPUTE   = 2'd3
   } mmtb_op_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS_M      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLS_N      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH_K     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIAS_ENABLE = 2'd3;

   typedef struct packed {
      logic [1:0]                       operation;
      logic [IDX_FIELD_BITS-1:0]        row_index;
      logic [IDX_FIELD_BITS-1:0]        col_index;
      logic signed [ELEM_FIELD_BITS-1:0] element_value;
   } mmtb_req_type;

   typedef struct packed {
      logic signed [RES_BITS-1:0]  result_value;
      logic [IDX_FIELD_BITS-1:0]   result_col;
      logic                        last_in_row;
   } mmtb_rsp_type;

   // One step of the inner loop as it moves through the pipeline
   typedef struct packed {
      logic                      valid;
      logic                      first;
      logic                      last_k;
      logic                      last_col;
      logic [IDX_FIELD_BITS-1:0] col;
   } mmtb_pipe_type;

endpackage

`default_nettype wire

// ----- src/mmtb_seq.sv -----
// Loop sequencer: walks column n and depth k for one result row and issues
// one multiply-accumulate step per cycle. Uses mmtb_pkg for the step word.
`default_nettype none

module mmtb_seq #(
   parameter int MAX_DIM = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           launch,
   input  wire logic [$clog2(MAX_DIM)-1:0]     row_sel,
   input  wire logic [$clog2(MAX_DIM+1)-1:0]   n_cnt,
   input  wire logic [$clog2(MAX_DIM+1)-1:0]   k_cnt,
   output logic [$clog2(MAX_DIM)-1:0]          row_idx,
   output logic [$clog2(MAX_DIM)-1:0]          col_idx,
   output logic [$clog2(MAX_DIM)-1:0]          dep_idx,
   output mmtb_pkg::mmtb_pipe_type             step_out,
   output logic                                busy
);

   localparam int IW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   seq_state_type           state_ff, state_in;
   logic [IW-1:0]           n_ff, n_in;
   logic [IW-1:0]           k_ff, k_in;
   logic [IW-1:0]           row_ff;
   mmtb_pkg::mmtb_pipe_type step_in, step_ff;
   logic                    k_last, n_last, issue;

   assign k_last = (DW'(k_ff) == (k_cnt - DW'(1)));
   assign n_last = (DW'(n_ff) == (n_cnt - DW'(1)));
   assign issue  = (state_ff == SEQ_RUN);

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (launch) begin
               state_in = SEQ_RUN;
               n_in     = '0;
               k_in     = '0;
            end
         end
         SEQ_RUN: begin
            if (k_last) begin
               k_in = '0;
               if (n_last) begin
                  state_in = SEQ_IDLE;
               end else begin
                  n_in = n_ff + IW'(1);
               end
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      step_in.valid    = issue;
      step_in.first    = (k_ff == '0);
      step_in.last_k   = k_last;
      step_in.last_col = n_last;
      step_in.col      = mmtb_pkg::IDX_FIELD_BITS'(n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         n_ff     <= '0;
         k_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
      end
   end

   // Hold the row for the whole request
   always_ff @(posedge clock) begin
      if (launch) begin
         row_ff <= row_sel;
      end
   end

   assign row_idx  = row_ff;
   assign col_idx  = n_ff;
   assign dep_idx  = k_ff;
   assign step_out = step_ff;
   assign busy     = issue | step_ff.valid;

endmodule

`default_nettype wire

// ----- src/mmtb_mac.sv -----
// Shared multiply-accumulate unit: one registered product, one 40-bit adder.
// The bias is folded in on the first depth step. Uses mmtb_pkg types.
`default_nettype none

module mmtb_mac #(
   parameter int EW = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic signed [EW-1:0]    a_data,
   input  wire logic signed [EW-1:0]    b_data,
   input  wire logic signed [EW-1:0]    bias_data,
   input  wire logic                    bias_enable,
   input  wire mmtb_pkg::mmtb_pipe_type step_in,
   output logic                         rsp_strobe,
   output mmtb_pkg::mmtb_rsp_type       rsp_data,
   output logic                         busy
);

   localparam int RB = mmtb_pkg::RES_BITS;
   localparam int PB = 2 * EW;

   logic signed [PB-1:0]                  prod_ff;
   logic signed [RB-1:0]                  bias_term_ff, bias_term_in;
   logic signed [RB-1:0]                  prod_ext;
   logic signed [RB-1:0]                  acc_ff, acc_in;
   mmtb_pkg::mmtb_pipe_type               step_ff;
   logic                                  strobe_ff;
   logic [mmtb_pkg::IDX_FIELD_BITS-1:0]   col_ff;
   logic                                  last_ff;

   always_comb begin
      if (bias_enable) begin
         bias_term_in = {{(RB-EW){bias_data[EW-1]}}, bias_data} <<< mmtb_pkg::BIAS_SHIFT;
      end else begin
         bias_term_in = '0;
      end
   end

   assign prod_ext = {{(RB-PB){prod_ff[PB-1]}}, prod_ff};
   assign acc_in   = (step_ff.first ? bias_term_ff : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      prod_ff      <= a_data * b_data;
      bias_term_ff <= bias_term_in;
      if (step_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (step_ff.valid && step_ff.last_k) begin
         col_ff  <= step_ff.col;
         last_ff <= step_ff.last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         strobe_ff <= step_ff.valid & step_ff.last_k;
      end
   end

   always_comb begin
      rsp_data.result_value = acc_ff;
      rsp_data.result_col   = col_ff;
      rsp_data.last_in_row  = last_ff;
   end

   assign rsp_strobe = strobe_ff;
   assign busy       = step_ff.valid;

endmodule

`default_nettype wire

// ----- src/matrix_multiply_transposed_b_bias.sv -----
// Matrix multiply with transposed B and per-column bias, signed fixed point.
// Top level: CSRs, the A, B and bias stores, sequencer and shared MAC unit.
//
// Usage:
//   Request channel: start/busy with req_data. A request is taken on a clock
//   edge where start is high and busy is low. Load A, load B and load bias
//   requests write one Q8.8 element and finish in that cycle (busy stays low).
//   A compute request for row m runs C[m][n] = sum_k A[m][k]*B[n][k]
//   (+ bias[n] << 8) for n = 0 .. cols_n-1 and raises busy until the last
//   product has been accumulated. A compute for a row not below rows_m is
//   dropped with no response.
//   Response channel: rsp_strobe marks each result for one cycle; results come
//   in column order, last_in_row set on the final column. The receiver cannot
//   stall, so a result is simply gone after its strobe cycle.
//   CSR channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
//   always high. Write only while busy is low and no result is pending.
// Timing: one multiply-accumulate per cycle through a single shared multiplier
// and 40-bit adder. Results are strobed in column order, and the last one is
// strobed as busy drops.
// Reset: CSRs return to rows_m = cols_n = depth_k = 64, bias off; the stores
// are not cleared and must be loaded before use.
`default_nettype none

module matrix_multiply_transposed_b_bias #(
   parameter int MAX_DIM   = 64,
   parameter int ELEM_BITS = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   output logic                                           busy,
   input  wire mmtb_pkg::mmtb_req_type                    req_data,
   output logic                                           rsp_strobe,
   output mmtb_pkg::mmtb_rsp_type                         rsp_data,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [mmtb_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  wire logic [mmtb_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   localparam int EW = (ELEM_BITS < 16) ? ELEM_BITS : 16;
   localparam int IW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);
   localparam int CB = mmtb_pkg::CSR_DATA_BITS;

   // Configuration registers
   logic [CB-1:0] rows_m_ff, cols_n_ff, depth_k_ff;
   logic          bias_enable_ff;

   // Stores
   logic [EW-1:0] a_store_ff    [MAX_DIM*MAX_DIM];
   logic [EW-1:0] b_store_ff    [MAX_DIM*MAX_DIM];
   logic [EW-1:0] bias_store_ff [MAX_DIM];
   logic [EW-1:0] a_rd_ff, b_rd_ff, bias_rd_ff;

   mmtb_pkg::mmtb_op_type   op;
   mmtb_pkg::mmtb_pipe_type step;
   logic                    accept, load_ok, launch;
   logic                    we_a, we_b, we_bias;
   logic [EW-1:0]           elem;
   logic [AW-1:0]           w_addr, ra_addr, rb_addr;
   logic [DW-1:0]           rows_eff, cols_eff, depth_eff;
   logic [IW-1:0]           row_idx, col_idx, dep_idx;
   logic                    seq_busy, mac_busy;

   function automatic logic [DW-1:0] eff_dim(input logic [CB-1:0] v);
      if (v == '0) begin
         return DW'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         return DW'(MAX_DIM);
      end else begin
         return DW'(v);
      end
   endfunction

   assign rows_eff  = eff_dim(rows_m_ff);
   assign cols_eff  = eff_dim(cols_n_ff);
   assign depth_eff = eff_dim(depth_k_ff);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff      <= CB'(64);
         cols_n_ff      <= CB'(64);
         depth_k_ff     <= CB'(64);
         bias_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            mmtb_pkg::CSR_ROWS_M:      rows_m_ff      <= csr_data;
            mmtb_pkg::CSR_COLS_N:      cols_n_ff      <= csr_data;
            mmtb_pkg::CSR_DEPTH_K:     depth_k_ff     <= csr_data;
            mmtb_pkg::CSR_BIAS_ENABLE: bias_enable_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Request decode
   assign accept  = start & ~busy;
   assign op      = mmtb_pkg::mmtb_op_type'(req_data.operation);
   assign load_ok = (32'(req_data.row_index) < 32'(MAX_DIM))
                 && (32'(req_data.col_index) < 32'(MAX_DIM));
   assign elem    = req_data.element_value[EW-1:0];

   always_comb begin
      we_a    = 1'b0;
      we_b    = 1'b0;
      we_bias = 1'b0;
      launch  = 1'b0;
      unique case (op)
         mmtb_pkg::OP_LOAD_A:    we_a    = accept & load_ok;
         mmtb_pkg::OP_LOAD_B:    we_b    = accept & load_ok;
         mmtb_pkg::OP_LOAD_BIAS: we_bias = accept & (32'(req_data.col_index) < 32'(MAX_DIM));
         mmtb_pkg::OP_COMPUTE:   launch  = accept & (32'(req_data.row_index) < 32'(rows_eff));
         default: begin
         end
      endcase
   end

   assign w_addr  = AW'(req_data.row_index) * AW'(MAX_DIM) + AW'(req_data.col_index);
   assign ra_addr = AW'(row_idx) * AW'(MAX_DIM) + AW'(dep_idx);
   assign rb_addr = AW'(col_idx) * AW'(MAX_DIM) + AW'(dep_idx);

   always_ff @(posedge clock) begin
      if (we_a) begin
         a_store_ff[w_addr] <= elem;
      end
      a_rd_ff <= a_store_ff[ra_addr];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         b_store_ff[w_addr] <= elem;
      end
      b_rd_ff <= b_store_ff[rb_addr];
   end

   always_ff @(posedge clock) begin
      if (we_bias) begin
         bias_store_ff[IW'(req_data.col_index)] <= elem;
      end
      bias_rd_ff <= bias_store_ff[col_idx];
   end

   mmtb_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .launch   (launch),
      .row_sel  (IW'(req_data.row_index)),
      .n_cnt    (cols_eff),
      .k_cnt    (depth_eff),
      .row_idx  (row_idx),
      .col_idx  (col_idx),
      .dep_idx  (dep_idx),
      .step_out (step),
      .busy     (seq_busy)
   );

   mmtb_mac #(
      .EW (EW)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .a_data      (a_rd_ff),
      .b_data      (b_rd_ff),
      .bias_data   (bias_rd_ff),
      .bias_enable (bias_enable_ff),
      .step_in     (step),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .busy        (mac_busy)
   );

   assign busy = seq_busy | mac_busy;

endmodule

`default_nettype wire
